[src/ipr_pkg.sv]
// Shared types and constants for the integer pixel replicate scaler.
package ipr_pkg;

  localparam int PIX_W   = 24;
  localparam int Q_DEPTH = 4;

  localparam logic [6:0] MAX_FACTOR = 7'd100;

  // Input operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_REQ  = 1'b1;

  // Result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD   = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Description of one result, handed from front to back
  typedef struct packed {
    logic image_done;
    logic row_done;
    logic kind;
  } desc_t;

endpackage

[src/integer_pixel_replicate_scaler.sv]
// Top level of the integer pixel replicate scaler: registers, front, line store, back.
//
// Input stream: in_tuser selects the operation (push a source pixel or request
// the next result), in_tdata carries the pixel. Pushes fill a one-row line store;
// once a full row is in, each request returns one result: the row replayed
// scale_factor times, every pixel repeated scale_factor times, each output row
// closed by 0 to 3 zero padding items. Pushes during a replay and requests while
// the row is still filling are taken and dropped without a result.
// Output stream: out_tdata pixel, out_tlast on the last item of a row,
// out_tuser carries the item kind and the end-of-image flag.
// Throughput: one item per cycle on both sides while the receiver does not stall.
// A request's result passes through the line store's registered read, with its
// description held in the alignment stage, and then through the queue to out_*.
// When the receiver stalls, results collect in a four-entry queue; in_tready
// drops once the queue and the read stage hold four items.
// Reset (rst_n, synchronous) empties the queue, returns to filling, clears all
// counters and sets the three registers to 1. Registers are to be written by the user
// over the APB-style port while the block is idle; the block does not enforce it.
module integer_pixel_replicate_scaler #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic        in_tuser,   // operation [0]
  // Output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic [1:0]  out_tuser,  // item_kind [0], image_done [1]
  output logic        out_tlast,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > 11) ? CW : 11;

  logic [6:0]  scale_r;
  logic [10:0] width_r;
  logic [10:0] height_r;

  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [6:0]  eff_n;
  logic [CW-1:0] eff_w;
  logic [WW-1:0] width_ext;
  logic [10:0] eff_h;
  logic [3:0]  pad_prod;
  logic [1:0]  pad_len;

  logic        in_acc;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ipr_pkg::PIX_W-1:0] ram_wdata, ram_rdata;
  logic        desc_vld;
  ipr_pkg::desc_t desc;
  logic        space;

  // Configuration register writes
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 7'd1;
      width_r  <= 11'd1;
      height_r <= 11'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        ipr_pkg::REG_SCALE:  scale_r  <= cfg_pwdata[6:0];
        ipr_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[10:0];
        ipr_pkg::REG_HEIGHT: height_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      ipr_pkg::REG_SCALE:  cfg_prdata = {25'd0, scale_r};
      ipr_pkg::REG_WIDTH:  cfg_prdata = {21'd0, width_r};
      ipr_pkg::REG_HEIGHT: cfg_prdata = {21'd0, height_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // Clamp the registers to their working ranges
  assign width_ext = WW'(width_r);

  always_comb begin
    if (scale_r == 7'd0) begin
      eff_n = 7'd1;
    end else if (scale_r > ipr_pkg::MAX_FACTOR) begin
      eff_n = ipr_pkg::MAX_FACTOR;
    end else begin
      eff_n = scale_r;
    end
    if (width_r == 11'd0) begin
      eff_w = CW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_ext);
    end
    eff_h = (height_r == 11'd0) ? 11'd1 : height_r;
  end

  // Row padding: (width * factor) mod 4 from the low bits only
  assign pad_prod = eff_w[1:0] * eff_n[1:0];
  assign pad_len  = pad_prod[1:0];

  assign in_tready = space;
  assign in_acc    = in_tvalid && in_tready;

  ipr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_op     (in_tuser),
    .in_pix    (in_tdata),
    .eff_n     (eff_n),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .pad_len   (pad_len),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .desc_vld  (desc_vld),
    .desc      (desc)
  );

  ipr_ram #(
    .WIDTH (ipr_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ipr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_vld   (desc_vld),
    .desc       (desc),
    .rd_data    (ram_rdata),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[src/ipr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ipr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ipr_front.sv]
// Front end: accepts items, fills the line store and sequences the replay.
module ipr_front #(
  parameter int  MAX_WIDTH = 1024,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_acc,
  input  logic                     in_op,
  input  logic [ipr_pkg::PIX_W-1:0] in_pix,
  input  logic [6:0]               eff_n,
  input  logic [CW-1:0]            eff_w,
  input  logic [10:0]              eff_h,
  input  logic [1:0]               pad_len,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [ipr_pkg::PIX_W-1:0] ram_wdata,
  output logic                     ram_re,
  output logic [AW-1:0]            ram_raddr,
  output logic                     desc_vld,
  output ipr_pkg::desc_t           desc
);

  typedef enum logic [1:0] {
    MODE_FILL   = 2'b01,
    MODE_REPLAY = 2'b10
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] pix_idx_r, pix_idx_nxt;
  logic [6:0]  pix_rep_r, pix_rep_nxt;
  logic [6:0]  row_rep_r, row_rep_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [10:0] src_row_r, src_row_nxt;

  logic [CW:0]  fill_inc;
  logic [CW:0]  pix_idx_inc;
  logic [7:0]   pix_rep_inc;
  logic [7:0]   row_rep_inc;
  logic [2:0]   pad_inc;
  logic [11:0]  src_row_inc;
  logic         row_end;
  logic         image_end;

  assign fill_inc    = {1'b0, fill_r} + 1'b1;
  assign pix_idx_inc = {1'b0, pix_idx_r} + 1'b1;
  assign pix_rep_inc = {1'b0, pix_rep_r} + 1'b1;
  assign row_rep_inc = {1'b0, row_rep_r} + 1'b1;
  assign pad_inc     = {1'b0, pad_r} + 1'b1;
  assign src_row_inc = {1'b0, src_row_r} + 1'b1;

  assign ram_wdata = in_pix;
  assign ram_waddr = fill_r[AW-1:0];
  assign ram_raddr = pix_idx_r[AW-1:0];

  // Classify the accepted item and advance the counters
  always_comb begin
    mode_nxt    = mode_r;
    fill_nxt    = fill_r;
    pix_idx_nxt = pix_idx_r;
    pix_rep_nxt = pix_rep_r;
    row_rep_nxt = row_rep_r;
    pad_nxt     = pad_r;
    src_row_nxt = src_row_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    desc_vld    = 1'b0;
    desc        = '0;
    row_end     = 1'b0;
    image_end   = 1'b0;
    if (in_acc) begin
      unique case (mode_r)
        MODE_FILL: begin
          if (in_op == ipr_pkg::OP_PUSH) begin
            ram_we = (fill_r < CW'(MAX_WIDTH));
            if (fill_inc >= {1'b0, eff_w}) begin
              mode_nxt    = MODE_REPLAY;
              fill_nxt    = '0;
              row_rep_nxt = '0;
              pix_idx_nxt = '0;
              pix_rep_nxt = '0;
              pad_nxt     = '0;
            end else begin
              fill_nxt = fill_inc[CW-1:0];
            end
          end
        end
        MODE_REPLAY: begin
          if (in_op == ipr_pkg::OP_REQ) begin
            desc_vld = 1'b1;
            if (pix_idx_r < eff_w) begin
              // Pixel phase: read the stored pixel, step the repeat counters
              ram_re    = 1'b1;
              desc.kind = ipr_pkg::KIND_PIXEL;
              if (pix_rep_inc >= {1'b0, eff_n}) begin
                pix_rep_nxt = '0;
                pix_idx_nxt = pix_idx_inc[CW-1:0];
                row_end     = (pix_idx_inc >= {1'b0, eff_w}) && (pad_len == 2'd0);
              end else begin
                pix_rep_nxt = pix_rep_inc[6:0];
              end
            end else begin
              // Padding phase
              desc.kind = ipr_pkg::KIND_PAD;
              pad_nxt   = pad_inc[1:0];
              row_end   = (pad_inc >= {1'b0, pad_len});
            end
            if (row_end) begin
              pix_idx_nxt = '0;
              pix_rep_nxt = '0;
              pad_nxt     = '0;
              if (row_rep_inc >= {1'b0, eff_n}) begin
                row_rep_nxt = '0;
                mode_nxt    = MODE_FILL;
                fill_nxt    = '0;
                if (src_row_inc >= {1'b0, eff_h}) begin
                  src_row_nxt = '0;
                  image_end   = 1'b1;
                end else begin
                  src_row_nxt = src_row_inc[10:0];
                end
              end else begin
                row_rep_nxt = row_rep_inc[6:0];
              end
            end
            desc.row_done   = row_end;
            desc.image_done = image_end;
          end
        end
        default: begin
          mode_nxt = MODE_FILL;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FILL;
      fill_r    <= '0;
      pix_idx_r <= '0;
      pix_rep_r <= '0;
      row_rep_r <= '0;
      pad_r     <= '0;
      src_row_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      fill_r    <= fill_nxt;
      pix_idx_r <= pix_idx_nxt;
      pix_rep_r <= pix_rep_nxt;
      row_rep_r <= row_rep_nxt;
      pad_r     <= pad_nxt;
      src_row_r <= src_row_nxt;
    end
  end

  // An image end always closes a row
  a_image_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
    desc_vld && desc.image_done |-> desc.row_done)
    else $error("image end without row end");

  // Requests while filling give nothing
  a_no_result_filling: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (mode_r == MODE_FILL) |-> !desc_vld)
    else $error("result issued while filling");

  // Results come only from accepted requests
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    desc_vld |-> in_acc && (in_op == ipr_pkg::OP_REQ))
    else $error("result without request");

endmodule

[src/ipr_back.sv]
// Back end: joins read data with result descriptions and queues items for output.
module ipr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      desc_vld,
  input  ipr_pkg::desc_t            desc,
  input  logic [ipr_pkg::PIX_W-1:0] rd_data,
  output logic                      space,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ipr_pkg::PIX_W-1:0] out_tdata,
  output logic [1:0]                out_tuser,
  output logic                      out_tlast
);

  localparam int PW = $clog2(ipr_pkg::Q_DEPTH);
  localparam int NW = $clog2(ipr_pkg::Q_DEPTH + 1);

  typedef struct packed {
    ipr_pkg::desc_t            desc;
    logic [ipr_pkg::PIX_W-1:0] pix;
  } q_item_t;

  logic           stg_vld_r;
  ipr_pkg::desc_t stg_desc_r;
  q_item_t        q_r [ipr_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic [NW:0]    used;
  logic           push, pop;
  q_item_t        push_item;
  q_item_t        head;

  // Align the description with the registered RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= desc_vld;
    end
  end

  always_ff @(posedge clk) begin
    stg_desc_r <= desc;
  end

  assign push           = stg_vld_r;
  assign push_item.desc = stg_desc_r;
  assign push_item.pix  = (stg_desc_r.kind == ipr_pkg::KIND_PAD) ? '0 : rd_data;

  assign head = q_r[rd_ptr_r];
  assign pop  = out_tvalid && out_tready;

  // Reserve room for the item in the alignment stage
  assign used  = {1'b0, cnt_r} + {{NW{1'b0}}, stg_vld_r};
  assign space = (used < (NW + 1)'(ipr_pkg::Q_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = head.pix;
  assign out_tuser  = {head.desc.image_done, head.desc.kind};
  assign out_tlast  = head.desc.row_done;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(ipr_pkg::Q_DEPTH))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(stg_vld_r && (cnt_r == NW'(ipr_pkg::Q_DEPTH)) && !pop))
    else $error("queue overflow");

  a_pad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == ipr_pkg::KIND_PAD) |-> (out_tdata == '0))
    else $error("padding item carries data");

endmodule
